[rtl/cpc_pkg.sv]
package cpc_pkg;

	localparam int unsigned DUTY_W   = 6;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 6'd50;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 15;

	// Register map of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_MODE           = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_OV        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERCURRENT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERTEMP       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SHUTDOWN_TEMP  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_THRESH = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_HIGH    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_LOW     = 3'd7;

	localparam logic [1:0] MODE_INFO    = 2'd0;
	localparam logic [1:0] MODE_CHARGE  = 2'd1;
	localparam logic [1:0] MODE_BALANCE = 2'd2;

	localparam logic [2:0] ST_NORMAL      = 3'd0;
	localparam logic [2:0] ST_OVERVOLTAGE = 3'd1;
	localparam logic [2:0] ST_OVERCURRENT = 3'd2;
	localparam logic [2:0] ST_OVERTEMP    = 3'd3;
	localparam logic [2:0] ST_SHUTDOWN    = 3'd4;

	localparam logic [1:0]         RST_MODE           = MODE_INFO;
	localparam logic [12:0]        RST_CELL_OV        = 13'd4400;
	localparam logic [14:0]        RST_OVERCURRENT    = 15'd2000;
	localparam logic signed [11:0] RST_OVERTEMP       = 12'sd400;
	localparam logic signed [11:0] RST_SHUTDOWN_TEMP  = 12'sd450;
	localparam logic [12:0]        RST_BALANCE_THRESH = 13'd3700;
	localparam logic [13:0]        RST_SUPPLY_HIGH    = 14'd8450;
	localparam logic [13:0]        RST_SUPPLY_LOW     = 14'd8350;

	typedef struct packed {
		logic [13:0]        pack_mv;
		logic [12:0]        cell2_mv;
		logic signed [15:0] current_ma;
		logic signed [11:0] temp_dc;
		logic [13:0]        supply_mv;
	} sample_t;

	typedef struct packed {
		logic              charge_switch;
		logic              balance_cell1;
		logic              balance_cell2;
		logic              relay_on;
		logic [DUTY_W-1:0] pwm_duty;
		logic [2:0]        status;
	} result_t;

endpackage

[rtl/two_cell_charge_protect_controller.sv]
// Two-cell charge protection controller. Each sample beat carries one averaged
// measurement set and yields exactly one result beat, through sample_s1 and then
// result_s2; a new sample is taken every cycle while the result side is not
// stalled, set by the single register stage on each side of the decision logic.
// A temperature at or above the shutdown level latches the relay off until
// reset, and from then on every result reports status 4 with the duty frozen.
// In charge mode the PWM duty is regulated once both cells reach the balance
// threshold, saturating between 0 and full duty (50). Configuration writes are
// always ready and must only be issued while no sample is in flight.
module two_cell_charge_protect_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  cpc_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output cpc_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers.
	logic [1:0]         mode_q;
	logic [12:0]        cell_ov_q;
	logic [14:0]        overcurrent_q;
	logic signed [11:0] overtemp_q;
	logic signed [11:0] shutdown_temp_q;
	logic [12:0]        balance_thresh_q;
	logic [13:0]        supply_high_q;
	logic [13:0]        supply_low_q;

	// Block state.
	logic [cpc_pkg::DUTY_W-1:0] duty_q;
	logic                       shutdown_q;

	// Pipeline.
	logic              valid_s1;
	cpc_pkg::sample_t  sample_s1;
	logic              valid_s2;
	cpc_pkg::result_t  result_s2;

	logic s2_load;
	logic s1_load;

	// Decision logic.
	logic signed [14:0]         cell1_mv;
	logic signed [14:0]         cell2_mv;
	logic signed [14:0]         bal_thresh;
	logic signed [14:0]         ov_thresh;
	logic                       trip;
	logic                       shutdown_next;
	logic                       both_high;
	logic [cpc_pkg::DUTY_W-1:0] duty_next;
	cpc_pkg::result_t           result_next;

	assign cfg_ready = 1'b1;

	assign s2_load      = !valid_s2 || !result_stall;
	assign s1_load      = !valid_s1 || s2_load;
	assign sample_stall = !s1_load;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= cpc_pkg::RST_MODE;
			cell_ov_q        <= cpc_pkg::RST_CELL_OV;
			overcurrent_q    <= cpc_pkg::RST_OVERCURRENT;
			overtemp_q       <= cpc_pkg::RST_OVERTEMP;
			shutdown_temp_q  <= cpc_pkg::RST_SHUTDOWN_TEMP;
			balance_thresh_q <= cpc_pkg::RST_BALANCE_THRESH;
			supply_high_q    <= cpc_pkg::RST_SUPPLY_HIGH;
			supply_low_q     <= cpc_pkg::RST_SUPPLY_LOW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpc_pkg::REG_MODE:           mode_q           <= cfg_data[1:0];
				cpc_pkg::REG_CELL_OV:        cell_ov_q        <= cfg_data[12:0];
				cpc_pkg::REG_OVERCURRENT:    overcurrent_q    <= cfg_data[14:0];
				cpc_pkg::REG_OVERTEMP:       overtemp_q       <= cfg_data[11:0];
				cpc_pkg::REG_SHUTDOWN_TEMP:  shutdown_temp_q  <= cfg_data[11:0];
				cpc_pkg::REG_BALANCE_THRESH: balance_thresh_q <= cfg_data[12:0];
				cpc_pkg::REG_SUPPLY_HIGH:    supply_high_q    <= cfg_data[13:0];
				cpc_pkg::REG_SUPPLY_LOW:     supply_low_q     <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cell1_mv   = $signed({1'b0, sample_s1.pack_mv}) - $signed({2'b00, sample_s1.cell2_mv});
		cell2_mv   = $signed({2'b00, sample_s1.cell2_mv});
		bal_thresh = $signed({2'b00, balance_thresh_q});
		ov_thresh  = $signed({2'b00, cell_ov_q});

		trip          = sample_s1.temp_dc >= shutdown_temp_q;
		shutdown_next = shutdown_q || trip;
		both_high     = (cell1_mv >= bal_thresh) && (cell2_mv >= bal_thresh);

		duty_next   = duty_q;
		result_next = '0;
		result_next.relay_on = !shutdown_next;

		if (shutdown_next) begin
			result_next.status = cpc_pkg::ST_SHUTDOWN;
		end else begin
			case (mode_q)
				cpc_pkg::MODE_CHARGE: begin
					// The step-down test wins when the supply band is crossed.
					if (both_high) begin
						if (sample_s1.supply_mv > supply_high_q) begin
							if (duty_q != '0)
								duty_next = duty_q - 1'b1;
						end else if (sample_s1.supply_mv < supply_low_q) begin
							if (duty_q < cpc_pkg::DUTY_MAX)
								duty_next = duty_q + 1'b1;
						end else begin
							duty_next = cpc_pkg::DUTY_MAX;
						end
					end
					if ((cell1_mv >= ov_thresh) || (cell2_mv >= ov_thresh))
						result_next.status = cpc_pkg::ST_OVERVOLTAGE;
					else if (sample_s1.current_ma > $signed({1'b0, overcurrent_q}))
						result_next.status = cpc_pkg::ST_OVERCURRENT;
					else if (sample_s1.temp_dc > overtemp_q)
						result_next.status = cpc_pkg::ST_OVERTEMP;
					else
						result_next.charge_switch = 1'b1;
				end
				cpc_pkg::MODE_BALANCE: begin
					result_next.balance_cell1 = cell1_mv >= bal_thresh;
					result_next.balance_cell2 = cell2_mv >= bal_thresh;
				end
				default: ;
			endcase
		end

		result_next.pwm_duty = duty_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			duty_q     <= cpc_pkg::DUTY_MAX;
			shutdown_q <= 1'b0;
		end else begin
			if (s1_load)
				valid_s1 <= sample_valid;
			if (s2_load) begin
				valid_s2 <= valid_s1;
				// State only moves when a sample leaves the input register.
				if (valid_s1) begin
					duty_q     <= duty_next;
					shutdown_q <= shutdown_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && sample_valid)
			sample_s1 <= sample;
		if (s2_load && valid_s1)
			result_s2 <= result_next;
	end

	a_shutdown_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		shutdown_q |=> shutdown_q)
		else $error("shutdown latch cleared without reset");

	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= cpc_pkg::DUTY_MAX)
		else $error("duty above full scale");

	a_relay_off_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.relay_on) |->
			(result.status == cpc_pkg::ST_SHUTDOWN && !result.charge_switch))
		else $error("relay off without shutdown status");

	a_switch_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.charge_switch) |->
			(result.status == cpc_pkg::ST_NORMAL && result.relay_on))
		else $error("charge switch closed during a fault");

endmodule
